// ----- rtl/srct_pkg.sv -----
// shared types and constants for the sorted region claim table
`default_nettype none
package srct_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int OCC_W = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [31:0] offset;
		logic [31:0] size;
		logic [31:0] ident;
		logic [15:0] owner;
		logic        mode;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic ins_commit;
		logic rem_commit;
		logic valid;
		logic at_fill;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/srct_cell.sv -----
// one table slot: compares against the broadcast key and shifts with its neighbors
`default_nettype none
module srct_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  srct_pkg::cell_ctl_t ctl,
	input  wire  [31:0]         key_offset,
	input  wire  [31:0]         key_ident,
	input  srct_pkg::entry_t    new_entry,
	input  srct_pkg::entry_t    prev_entry,
	input  srct_pkg::entry_t    next_entry,
	input  wire                 prev_gt,
	input  wire                 prev_found,
	output srct_pkg::entry_t    entry,
	output logic                gt,
	output logic                found
);
	import srct_pkg::*;

	entry_t entry_q;
	logic   gt_q;
	logic   match_q;
	logic   is_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q    <= 1'b0;
			match_q <= 1'b0;
		end else if (ctl.capture) begin
			gt_q    <= ctl.valid && (entry_q.offset > key_offset);
			match_q <= ctl.valid && (entry_q.ident == key_ident);
		end
	end

	assign is_pos = !prev_gt && (gt_q || ctl.at_fill);
	assign found  = prev_found || match_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_commit) begin
			if (prev_gt) begin
				entry_q <= prev_entry;
			end else if (is_pos) begin
				entry_q <= new_entry;
			end
		end else if (ctl.rem_commit && found) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;
	assign gt    = gt_q;

endmodule
`default_nettype wire

// ----- rtl/sorted_region_claim_table.sv -----
// top level: chain of slot cells, fill count and result register
// A table of up to 16 region claims kept sorted by offset, one slot per cell.
// Each item has an accept step and an update step: in the accept cycle
// every cell compares its stored offset and identifier with the incoming
// item in parallel, and when the update commits every cell loads its own,
// its neighbor's or the new entry and the result is registered. A new item
// is accepted as soon as the previous one has updated the table, even while
// its result still waits; the update waits only when a result is already
// held and not taken. Inserts into a full table report full, removes of an
// absent identifier report not found, and neither changes the table.
`default_nettype none
module sorted_region_claim_table (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         op,
	input  wire  [31:0] ident,
	input  wire  [15:0] owner,
	input  wire         mode,
	input  wire  [31:0] new_offset,
	input  wire  [31:0] new_size,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  status,
	output logic [srct_pkg::OCC_W-1:0] occupancy
);
	import srct_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_UPD  = 2'b10
	} state_t;

	state_t              state_q;
	logic                op_q;
	entry_t              item_q;
	logic [CNT_W-1:0]    fill_q;
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic                accept;
	logic                commit;
	logic                full;
	logic                found_any;
	logic                ins_ok;
	logic                rem_ok;
	entry_t              cur_entry;
	entry_t              entries [TABLE_DEPTH];
	logic                gts     [TABLE_DEPTH];
	logic                founds  [TABLE_DEPTH];
	cell_ctl_t           ctls    [TABLE_DEPTH];

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign commit    = (state_q == S_UPD) && (!out_valid_q || out_ready);
	assign full      = (fill_q == CNT_W'(TABLE_DEPTH));
	assign found_any = founds[TABLE_DEPTH-1];
	assign ins_ok    = commit && (op_q == OP_INSERT) && !full;
	assign rem_ok    = commit && (op_q == OP_REMOVE) && found_any;

	assign cur_entry.offset = new_offset;
	assign cur_entry.size   = new_size;
	assign cur_entry.ident  = ident;
	assign cur_entry.owner  = owner;
	assign cur_entry.mode   = mode;

	genvar i;
	generate
		for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
			assign ctls[i].capture    = accept;
			assign ctls[i].ins_commit = ins_ok;
			assign ctls[i].rem_commit = rem_ok;
			assign ctls[i].valid      = (fill_q > CNT_W'(i));
			assign ctls[i].at_fill    = (fill_q == CNT_W'(i));

			srct_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctls[i]),
				.key_offset (new_offset),
				.key_ident  (ident),
				.new_entry  (item_q),
				.prev_entry ((i == 0) ? item_q : entries[(i == 0) ? 0 : i-1]),
				.next_entry (entries[(i == TABLE_DEPTH-1) ? i : i+1]),
				.prev_gt    ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i-1]),
				.prev_found ((i == 0) ? 1'b0 : founds[(i == 0) ? 0 : i-1]),
				.entry      (entries[i]),
				.gt         (gts[i]),
				.found      (founds[i])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			item_q <= cur_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				out_valid_q <= 1'b1;
				if (op_q == OP_INSERT) begin
					status_q <= full ? ST_FULL : ST_OK;
				end else begin
					status_q <= found_any ? ST_OK : ST_NOT_FOUND;
				end
				if (ins_ok) begin
					fill_q <= fill_q + CNT_W'(1);
				end else if (rem_ok) begin
					fill_q <= fill_q - CNT_W'(1);
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign occupancy = OCC_W'(fill_q);

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_accept_upd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_UPD))
		else $error("accepted beat did not start an update");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("insert did not grow the fill count");

	a_rem_count: assert property (@(posedge clk) disable iff (!arst_n)
		rem_ok |=> (fill_q == $past(fill_q) - CNT_W'(1)))
		else $error("remove did not shrink the fill count");

	a_result_status: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q && (status_q == ST_OK || status_q == ST_FULL
			|| status_q == ST_NOT_FOUND))
		else $error("update did not leave a valid result");
`endif

endmodule
`default_nettype wire

// ----- tb/claim_table_check.sv -----
// checker for the sorted region claim table: predicts each result beat and compares it
module claim_table_check (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	input  wire                      in_ready,
	input  wire                      op,
	input  wire [31:0]               ident,
	input  wire [15:0]               owner,
	input  wire                      mode,
	input  wire [31:0]               new_offset,
	input  wire [31:0]               new_size,
	input  wire                      out_valid,
	input  wire                      out_ready,
	input  wire [1:0]                status,
	input  wire [srct_pkg::OCC_W-1:0] occupancy,
	output int                       fail_count,
	output int                       open_results,
	output int                       full_hits,
	output int                       miss_hits,
	output int                       peak_fill
);
	import srct_pkg::*;

	typedef struct packed {
		logic [1:0]       status;
		logic [OCC_W-1:0] occupancy;
	} claim_result_t;

	entry_t        claim_tab [TABLE_DEPTH];
	int            claim_cnt;
	claim_result_t awaited_results [$];
	int            fails;
	int            fulls;
	int            misses;
	int            peak;

	function automatic logic [1:0] claim_insert(input entry_t e);
		int pos;
		int k;
		if (claim_cnt >= TABLE_DEPTH)
			return ST_FULL;
		pos = 0;
		// equal offsets keep arrival order
		while (pos < claim_cnt && claim_tab[pos].offset <= e.offset)
			pos++;
		for (k = claim_cnt; k > pos; k--)
			claim_tab[k] = claim_tab[k - 1];
		claim_tab[pos] = e;
		claim_cnt++;
		return ST_OK;
	endfunction

	function automatic logic [1:0] claim_remove(input logic [31:0] id);
		int pos;
		int k;
		pos = 0;
		while (pos < claim_cnt && claim_tab[pos].ident != id)
			pos++;
		if (pos >= claim_cnt)
			return ST_NOT_FOUND;
		for (k = pos; k + 1 < claim_cnt; k++)
			claim_tab[k] = claim_tab[k + 1];
		claim_cnt--;
		return ST_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		claim_result_t got;
		claim_result_t want;
		entry_t        e;
		logic [1:0]    st;
		if (!arst_n) begin
			claim_cnt = 0;
			awaited_results.delete();
			fails = 0;
			fulls = 0;
			misses = 0;
			peak = 0;
			fail_count <= 0;
			open_results <= 0;
			full_hits <= 0;
			miss_hits <= 0;
			peak_fill <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{status: status, occupancy: occupancy};
				if (awaited_results.size() == 0) begin
					if (fails < 10)
						$display("%0t unexpected result beat: status %0d occupancy %0d",
							$time, got.status, got.occupancy);
					fails++;
				end else begin
					want = awaited_results.pop_front();
					if (got.status !== want.status || got.occupancy !== want.occupancy) begin
						if (fails < 10)
							$display({"%0t bad result: expected status %0d occupancy %0d,",
								" got status %0d occupancy %0d"},
								$time, want.status, want.occupancy, got.status,
								got.occupancy);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (op == OP_INSERT) begin
					e.offset = new_offset;
					e.size = new_size;
					e.ident = ident;
					e.owner = owner;
					e.mode = mode;
					st = claim_insert(e);
				end else begin
					st = claim_remove(ident);
				end
				if (st == ST_FULL)
					fulls++;
				if (st == ST_NOT_FOUND)
					misses++;
				if (claim_cnt > peak)
					peak = claim_cnt;
				awaited_results.push_back('{status: st, occupancy: OCC_W'(claim_cnt)});
			end
			fail_count <= fails;
			open_results <= awaited_results.size();
			full_hits <= fulls;
			miss_hits <= misses;
			peak_fill <= peak;
		end
	end

endmodule

// ----- tb/sorted_region_claim_table_tb.sv -----
// testbench top: drives claim inserts and removes into the table and gives the verdict
module sorted_region_claim_table_tb;
	import srct_pkg::*;

	localparam int RANDOM_BEATS = 1800;
	localparam int PHASE_LEN = 150;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	wire              in_ready;
	logic             op = OP_INSERT;
	logic [31:0]      ident = '0;
	logic [15:0]      owner = '0;
	logic             mode = 1'b0;
	logic [31:0]      new_offset = '0;
	logic [31:0]      new_size = '0;
	wire              out_valid;
	logic             out_ready = 1'b0;
	wire  [1:0]       status;
	wire  [OCC_W-1:0] occupancy;

	int   fail_count;
	int   open_results;
	int   full_hits;
	int   miss_hits;
	int   peak_fill;
	int   insert_beats = 0;
	int   remove_beats = 0;
	logic steady = 1'b0;
	int   sink_wait = 0;
	int   sink_draw;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	sorted_region_claim_table i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.ident      (ident),
		.owner      (owner),
		.mode       (mode),
		.new_offset (new_offset),
		.new_size   (new_size),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.occupancy  (occupancy)
	);

	claim_table_check i_claim_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.ident        (ident),
		.owner        (owner),
		.mode         (mode),
		.new_offset   (new_offset),
		.new_size     (new_size),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.occupancy    (occupancy),
		.fail_count   (fail_count),
		.open_results (open_results),
		.full_hits    (full_hits),
		.miss_hits    (miss_hits),
		.peak_fill    (peak_fill)
	);

	// result side stall, drawn per beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_wait <= 0;
		end else if (out_valid && out_ready) begin
			sink_draw = steady ? 0 : $urandom_range(0, 6);
			sink_wait <= sink_draw;
			out_ready <= (sink_draw == 0);
		end else if (sink_wait > 0) begin
			sink_wait <= sink_wait - 1;
			out_ready <= (sink_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic offer_claim(input logic op_v, input logic [31:0] id_v,
		input logic [15:0] own_v, input logic md_v, input logic [31:0] off_v,
		input logic [31:0] sz_v);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= op_v;
		ident <= id_v;
		owner <= own_v;
		mode <= md_v;
		new_offset <= off_v;
		new_size <= sz_v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op_v == OP_INSERT)
			insert_beats++;
		else
			remove_beats++;
	endtask

	initial begin
		int          n;
		logic        grow;
		logic        add_claim;
		logic [31:0] rid;
		logic [31:0] roff;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then fill with field extremes and equal offsets
		offer_claim(OP_REMOVE, 32'd0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer_claim(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer_claim(OP_INSERT, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
		offer_claim(OP_INSERT, 32'd5, 16'h00A5, 1'b1, 32'h100, 32'h40);
		offer_claim(OP_INSERT, 32'd6, 16'h005A, 1'b0, 32'h100, 32'h80);
		offer_claim(OP_INSERT, 32'd5, 16'h1234, 1'b0, 32'h100, 32'h10);
		for (n = 0; n < 11; n++)
			offer_claim(OP_INSERT, 32'd100 + n, 16'($urandom), 1'($urandom), $urandom,
				$urandom);
		// full table, absent ident, duplicate idents
		offer_claim(OP_INSERT, 32'd200, 16'h0001, 1'b1, 32'h8000_0000, 32'd1);
		offer_claim(OP_REMOVE, 32'h1234_5678, 16'd0, 1'b0, 32'd0, 32'd0);
		repeat (3)
			offer_claim(OP_REMOVE, 32'd5, 16'($urandom), 1'($urandom), $urandom, $urandom);
		offer_claim(OP_REMOVE, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0);
		offer_claim(OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// alternate growing and shrinking phases so the table fills and drains
		for (n = 0; n < RANDOM_BEATS; n++) begin
			if (n % PHASE_LEN == 0)
				steady <= ($urandom_range(0, 3) == 0);
			if (n == RANDOM_BEATS / 2) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (open_results != 0)
					@(posedge clk);
			end
			grow = ((n / PHASE_LEN) % 2 == 0);
			add_claim = ($urandom_range(0, 99) < (grow ? 70 : 30));
			rid = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 19) : $urandom;
			roff = ($urandom_range(0, 3) == 0) ? (32'($urandom_range(0, 7)) << 29) : $urandom;
			offer_claim(add_claim ? OP_INSERT : OP_REMOVE, rid, 16'($urandom), 1'($urandom),
				roff, $urandom);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (open_results != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("tb: %0d inserts and %0d removes accepted, table peaked at %0d claims",
			insert_beats, remove_beats, peak_fill);
		$display("tb: %0d inserts rejected as full, %0d removes found nothing",
			full_hits, miss_hits);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/srct_pkg.sv
rtl/srct_cell.sv
rtl/sorted_region_claim_table.sv
tb/claim_table_check.sv
tb/sorted_region_claim_table_tb.sv
